// ----- rtl/core/i2crm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2crm_pkg
// types, codes and the bus sequence table of the i2c register master
// ----------------------------------------------------------------------------
package i2crm_pkg;

   localparam int PAUSE_W    = 8;
   localparam int ADDR_W     = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [PAUSE_W-1:0] PAUSE_RESET = 8'd5;
   localparam logic [ADDR_W-1:0]  ADDR_RESET  = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_TICKS  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDRESS_BASE = 1'd1;

   typedef enum logic [1:0] {
      OP_WRITE_REG  = 2'd0,
      OP_SELECT_REG = 2'd1,
      OP_READ       = 2'd2,
      OP_SET_BIT    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      E_END   = 4'd0,
      E_START = 4'd1,
      E_OADRW = 4'd2,
      E_OADRR = 4'd3,
      E_OREG  = 4'd4,
      E_ODATA = 4'd5,
      E_ACK   = 4'd6,
      E_IN    = 4'd7,
      E_NACK  = 4'd8,
      E_STOP  = 4'd9
   } elem_type;

   localparam logic [5:0] PH_WRITE_REG  = 6'd0;
   localparam logic [5:0] PH_SELECT_REG = 6'd9;
   localparam logic [5:0] PH_READ       = 6'd16;
   localparam logic [5:0] PH_SET_BIT    = 6'd23;

   function automatic logic [5:0] program_start(input op_type op);
      logic [5:0] p;
      unique case (op)
         OP_WRITE_REG:  p = PH_WRITE_REG;
         OP_SELECT_REG: p = PH_SELECT_REG;
         OP_READ:       p = PH_READ;
         OP_SET_BIT:    p = PH_SET_BIT;
         default:       p = PH_WRITE_REG;
      endcase
      return p;
   endfunction

   // bus element at each sequence position
   function automatic elem_type program_elem(input logic [5:0] ph);
      elem_type e;
      unique case (ph)
         6'd0, 6'd9, 6'd16, 6'd23, 6'd29, 6'd35:   e = E_START;
         6'd1, 6'd10, 6'd24, 6'd36:                e = E_OADRW;
         6'd17, 6'd30:                             e = E_OADRR;
         6'd2, 6'd4, 6'd6, 6'd11, 6'd13, 6'd18,
         6'd25, 6'd27, 6'd31, 6'd37, 6'd39, 6'd41: e = E_ACK;
         6'd3, 6'd12, 6'd26, 6'd38:                e = E_OREG;
         6'd5, 6'd40:                              e = E_ODATA;
         6'd19, 6'd32:                             e = E_IN;
         6'd20, 6'd33:                             e = E_NACK;
         6'd7, 6'd14, 6'd21, 6'd28, 6'd34, 6'd42:  e = E_STOP;
         default:                                  e = E_END;
      endcase
      return e;
   endfunction

   function automatic logic [2:0] slots_of(input elem_type e);
      logic [2:0] n;
      unique case (e)
         E_ACK, E_IN: n = 3'd3;
         E_STOP:      n = 3'd4;
         default:     n = 3'd2;
      endcase
      return n;
   endfunction

   function automatic logic is_out(input elem_type e);
      return (e == E_OADRW) || (e == E_OADRR) || (e == E_OREG) || (e == E_ODATA);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/i2c_register_master_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_master_core
// bit-level i2c master for register-mapped devices, tick driven
// ----------------------------------------------------------------------------
// Takes one request word per clock and returns one registered response
// word for each; a request is held off only while a response word sits
// stalled in the output register. Every word carries a tick flag; bus timing
// comes from counting ticks, pause_ticks (at least one) per bus slot, so a word
// may arrive every cycle. A command (write register, select register, read,
// set bit) is taken only while idle and runs as a fixed sequence of bus
// elements: start, address, ack, bytes, nack, stop. Acks are clocked but not
// checked. Each response word shows the scl and sda levels, busy, done and
// the last read byte.

module i2c_register_master_core
   import i2crm_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,

   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire                   req_tick,
   input  wire                   req_cmd_valid,
   input  wire  [1:0]            req_operation,
   input  wire  [2:0]            req_device,
   input  wire  [7:0]            req_register_index,
   input  wire  [7:0]            req_data_byte,
   input  wire  [2:0]            req_bit_position,
   input  wire                   req_bit_value,
   input  wire                   req_sda_in,

   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic                  rsp_scl_level,
   output logic                  rsp_sda_pull_low,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_read_valid,
   output logic [7:0]            rsp_read_data,

   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data
);

   logic [PAUSE_W-1:0] pause_cfg_ff;
   logic [ADDR_W-1:0]  addr_base_ff;

   logic       busy_ff, busy_in;
   logic [5:0] phase_ff, phase_in;
   logic [7:0] pause_ff, pause_in;
   logic [3:0] bit_ff, bit_in;
   logic [1:0] slot_ff, slot_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] read_ff, read_in;
   logic       scl_ff, scl_in;
   logic       sda_rel_ff, sda_rel_in;
   op_type     op_ff, op_in;
   logic [2:0] dev_ff, dev_in;
   logic [7:0] reg_ff, reg_in;
   logic [7:0] data_ff, data_in;
   logic [2:0] pos_ff, pos_in;
   logic       bitv_ff, bitv_in;
   logic       done_in, rvalid_in;

   logic       rsp_valid_ff;
   logic       rsp_scl_ff, rsp_pull_ff, rsp_busy_ff, rsp_done_ff, rsp_rvalid_ff;
   logic [7:0] rsp_data_ff;

   logic       accept;

   elem_type   cur_e, nxt_e, app_e;
   logic [1:0] app_slot;
   logic       do_app;
   logic [8:0] cnt;
   logic [2:0] slot_nxt;
   logic [7:0] mask;

   function automatic logic [7:0] out_byte(input elem_type e, input logic [ADDR_W-1:0] base,
                                           input logic [2:0] dev, input logic [7:0] rg,
                                           input logic [7:0] dt);
      logic [7:0] a;
      a = {1'b0, base | {3'b000, dev, 1'b0}};
      unique case (e)
         E_OADRW: return a;
         E_OADRR: return a | 8'h01;
         E_OREG:  return rg;
         default: return dt;
      endcase
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      busy_in    = busy_ff;
      phase_in   = phase_ff;
      pause_in   = pause_ff;
      bit_in     = bit_ff;
      slot_in    = slot_ff;
      shift_in   = shift_ff;
      read_in    = read_ff;
      scl_in     = scl_ff;
      sda_rel_in = sda_rel_ff;
      op_in      = op_ff;
      dev_in     = dev_ff;
      reg_in     = reg_ff;
      data_in    = data_ff;
      pos_in     = pos_ff;
      bitv_in    = bitv_ff;
      done_in    = 1'b0;
      rvalid_in  = 1'b0;
      do_app     = 1'b0;
      app_e      = E_END;
      app_slot   = 2'd0;
      cnt        = 9'd0;
      slot_nxt   = 3'd0;
      mask       = 8'h01 << pos_ff;
      cur_e      = program_elem(phase_ff);
      nxt_e      = E_END;

      if (!busy_ff) begin
         if (req_cmd_valid) begin
            op_in    = op_type'(req_operation);
            dev_in   = req_device;
            reg_in   = req_register_index;
            data_in  = req_data_byte;
            pos_in   = req_bit_position;
            bitv_in  = req_bit_value;
            busy_in  = 1'b1;
            pause_in = 8'd0;
            phase_in = program_start(op_type'(req_operation));
            nxt_e    = program_elem(phase_in);
            bit_in   = 4'd0;
            slot_in  = 2'd0;
            if (is_out(nxt_e)) begin
               shift_in = out_byte(nxt_e, addr_base_ff, dev_in, reg_in, data_in);
            end else if (nxt_e == E_IN) begin
               shift_in = 8'd0;
            end
            do_app   = 1'b1;
            app_e    = nxt_e;
         end
      end else if (req_tick) begin
         cnt = {1'b0, pause_ff} + 9'd1;
         if (cnt >= {1'b0, pause_cfg_ff}) begin
            pause_in = 8'd0;
            slot_nxt = {1'b0, slot_ff} + 3'd1;
            if (slot_nxt < slots_of(cur_e)) begin
               slot_in  = slot_nxt[1:0];
               do_app   = 1'b1;
               app_e    = cur_e;
               app_slot = slot_nxt[1:0];
            end else begin
               slot_in = 2'd0;
               if (is_out(cur_e)) begin
                  shift_in = {shift_ff[6:0], 1'b0};
               end
               if (is_out(cur_e) || cur_e == E_IN) begin
                  bit_in = bit_ff + 4'd1;
               end
               if ((is_out(cur_e) || cur_e == E_IN) && bit_in < 4'd8) begin
                  do_app = 1'b1;
                  app_e  = cur_e;
               end else begin
                  if (cur_e == E_IN) begin
                     if (op_ff == OP_READ) begin
                        read_in = shift_ff;
                     end else if (op_ff == OP_SET_BIT) begin
                        data_in = bitv_ff ? (shift_ff | mask) : (shift_ff & ~mask);
                     end
                  end
                  phase_in = phase_ff + 6'd1;
                  nxt_e    = program_elem(phase_in);
                  if (nxt_e == E_END) begin
                     busy_in   = 1'b0;
                     done_in   = 1'b1;
                     rvalid_in = (op_ff == OP_READ);
                  end else begin
                     bit_in  = 4'd0;
                     slot_in = 2'd0;
                     if (is_out(nxt_e)) begin
                        shift_in = out_byte(nxt_e, addr_base_ff, dev_ff, reg_ff, data_in);
                     end else if (nxt_e == E_IN) begin
                        shift_in = 8'd0;
                     end
                     do_app = 1'b1;
                     app_e  = nxt_e;
                  end
               end
            end
         end else begin
            pause_in = cnt[7:0];
         end
      end

      // line action of the current slot
      if (do_app) begin
         unique case (app_e)
            E_START: begin
               if (app_slot == 2'd0) sda_rel_in = 1'b0;
               else scl_in = 1'b0;
            end
            E_OADRW, E_OADRR, E_OREG, E_ODATA, E_NACK: begin
               if (app_slot == 2'd0) begin
                  scl_in = 1'b0;
               end else begin
                  sda_rel_in = (app_e == E_NACK) ? 1'b1 : shift_in[7];
                  scl_in     = 1'b1;
               end
            end
            E_ACK, E_IN: begin
               if (app_slot == 2'd0) begin
                  scl_in = 1'b0;
               end else if (app_slot == 2'd1) begin
                  sda_rel_in = 1'b1;
                  scl_in     = 1'b1;
               end else if (app_e == E_IN) begin
                  shift_in = {shift_in[6:0], req_sda_in};
               end
            end
            E_STOP: begin
               unique case (app_slot)
                  2'd0:    scl_in     = 1'b0;
                  2'd1:    sda_rel_in = 1'b0;
                  2'd2:    scl_in     = 1'b1;
                  default: sda_rel_in = 1'b1;
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pause_cfg_ff  <= PAUSE_RESET;
         addr_base_ff  <= ADDR_RESET;
         busy_ff       <= 1'b0;
         phase_ff      <= 6'd0;
         pause_ff      <= 8'd0;
         bit_ff        <= 4'd0;
         slot_ff       <= 2'd0;
         shift_ff      <= 8'd0;
         read_ff       <= 8'd0;
         scl_ff        <= 1'b1;
         sda_rel_ff    <= 1'b1;
         op_ff         <= OP_WRITE_REG;
         dev_ff        <= 3'd0;
         reg_ff        <= 8'd0;
         data_ff       <= 8'd0;
         pos_ff        <= 3'd0;
         bitv_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_scl_ff    <= 1'b1;
         rsp_pull_ff   <= 1'b0;
         rsp_busy_ff   <= 1'b0;
         rsp_done_ff   <= 1'b0;
         rsp_rvalid_ff <= 1'b0;
         rsp_data_ff   <= 8'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_PAUSE_TICKS) begin
               pause_cfg_ff <= csr_data[PAUSE_W-1:0];
            end else if (csr_index == CSR_ADDRESS_BASE) begin
               addr_base_ff <= csr_data[ADDR_W-1:0];
            end
         end
         if (accept) begin
            busy_ff       <= busy_in;
            phase_ff      <= phase_in;
            pause_ff      <= pause_in;
            bit_ff        <= bit_in;
            slot_ff       <= slot_in;
            shift_ff      <= shift_in;
            read_ff       <= read_in;
            scl_ff        <= scl_in;
            sda_rel_ff    <= sda_rel_in;
            op_ff         <= op_in;
            dev_ff        <= dev_in;
            reg_ff        <= reg_in;
            data_ff       <= data_in;
            pos_ff        <= pos_in;
            bitv_ff       <= bitv_in;
            rsp_valid_ff  <= 1'b1;
            rsp_scl_ff    <= scl_in;
            rsp_pull_ff   <= ~sda_rel_in;
            rsp_busy_ff   <= busy_in;
            rsp_done_ff   <= done_in;
            rsp_rvalid_ff <= rvalid_in;
            rsp_data_ff   <= read_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_scl_level    = rsp_scl_ff;
   assign rsp_sda_pull_low = rsp_pull_ff;
   assign rsp_busy_res     = rsp_busy_ff;
   assign rsp_done_res     = rsp_done_ff;
   assign rsp_read_valid   = rsp_rvalid_ff;
   assign rsp_read_data    = rsp_data_ff;

endmodule

`default_nettype wire

// ----- test/i2c_register_master_core_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_master_core_tb
// self-checking bench for the tick-driven i2c register master
// ----------------------------------------------------------------------------
// A driver feeds tick words from a queue and a monitor checks every response
// word against a bus-level predictor that tracks scl, sda, busy, done and the
// read byte. Directed commands cover the reset settings, the zero pause, the
// longest pause, odd and extreme address bases, every operation and commands
// offered while busy; random tick traffic with random sda levels follows.
// Both sides idle in random bursts, the receiver once holds off for a long
// stretch, and the settings change between phases, once in the middle of a command.

module i2c_register_master_core_tb;
   import i2crm_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 300;

   // bus element per sequence position, one nibble each, position 0 lowest
   localparam logic [175:0] BUS_SEQUENCE =
      176'h0965_6462_1987_6319_6462_1098_7631_0964_6210_9656_4621;

   typedef struct packed {
      logic       tick;
      logic       cmd_valid;
      op_type     op;
      logic [2:0] dev;
      logic [7:0] reg_idx;
      logic [7:0] data;
      logic [2:0] pos;
      logic       bitv;
      logic       sda;
   } tick_word_t;

   typedef struct packed {
      logic       scl;
      logic       sda_low;
      logic       busy;
      logic       done;
      logic       rvalid;
      logic [7:0] rdata;
   } bus_levels_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_tick = 1'b0;
   logic       req_cmd_valid = 1'b0;
   logic [1:0] req_operation = '0;
   logic [2:0] req_device = '0;
   logic [7:0] req_register_index = '0;
   logic [7:0] req_data_byte = '0;
   logic [2:0] req_bit_position = '0;
   logic       req_bit_value = 1'b0;
   logic       req_sda_in = 1'b0;

   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_pull_low;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_data;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   i2c_register_master_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_tick           (req_tick),
      .req_cmd_valid      (req_cmd_valid),
      .req_operation      (req_operation),
      .req_device         (req_device),
      .req_register_index (req_register_index),
      .req_data_byte      (req_data_byte),
      .req_bit_position   (req_bit_position),
      .req_bit_value      (req_bit_value),
      .req_sda_in         (req_sda_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_scl_level      (rsp_scl_level),
      .rsp_sda_pull_low   (rsp_sda_pull_low),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_read_data      (rsp_read_data),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   tick_word_t  pending_ticks[$];
   bus_levels_t expected_levels[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   bit          idle_en = 1'b0;
   int          hold_req_id = 0;
   int          hold_seen_id = 0;
   int          hold_left = 0;

   // predicted master state
   logic [7:0] cfg_pause;
   logic [6:0] cfg_addr_base;
   logic [5:0] bus_pos;
   logic [7:0] pause_cnt;
   logic [3:0] bit_cnt;
   logic [2:0] slot_idx;
   logic [7:0] shift_q;
   logic [7:0] read_q;
   logic       scl_q;
   logic       sda_q;
   logic       busy_q;
   op_type     cmd_op;
   logic [2:0] cmd_dev;
   logic [7:0] cmd_reg;
   logic [7:0] cmd_data;
   logic [2:0] cmd_pos;
   logic       cmd_bitv;

   function automatic elem_type elem_at(input logic [5:0] p);
      if (p >= 6'd44) return E_END;
      return elem_type'(BUS_SEQUENCE[4*p +: 4]);
   endfunction

   function automatic logic [2:0] slot_total(input elem_type e);
      if (e == E_ACK || e == E_IN) return 3'd3;
      if (e == E_STOP) return 3'd4;
      return 3'd2;
   endfunction

   function automatic logic sends_byte(input elem_type e);
      return e == E_OADRW || e == E_OADRR || e == E_OREG || e == E_ODATA;
   endfunction

   function automatic logic [5:0] seq_start(input op_type op);
      case (op)
         OP_WRITE_REG:  return PH_WRITE_REG;
         OP_SELECT_REG: return PH_SELECT_REG;
         OP_READ:       return PH_READ;
         default:       return PH_SET_BIT;
      endcase
   endfunction

   function automatic logic [7:0] byte_for(input elem_type e);
      logic [7:0] a;
      a = {1'b0, cfg_addr_base} | {4'b0, cmd_dev, 1'b0};
      case (e)
         E_OADRW: return a;
         E_OADRR: return a | 8'h01;
         E_OREG:  return cmd_reg;
         default: return cmd_data;
      endcase
   endfunction

   task automatic bus_reset();
      cfg_pause = PAUSE_RESET;
      cfg_addr_base = ADDR_RESET;
      bus_pos = '0;
      pause_cnt = '0;
      bit_cnt = '0;
      slot_idx = '0;
      shift_q = '0;
      read_q = '0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      busy_q = 1'b0;
      cmd_op = OP_WRITE_REG;
      cmd_dev = '0;
      cmd_reg = '0;
      cmd_data = '0;
      cmd_pos = '0;
      cmd_bitv = 1'b0;
   endtask

   task automatic begin_elem();
      elem_type e;
      e = elem_at(bus_pos);
      bit_cnt = '0;
      slot_idx = '0;
      if (sends_byte(e)) shift_q = byte_for(e);
      else if (e == E_IN) shift_q = 8'h00;
   endtask

   task automatic act_slot(input logic sda_in);
      elem_type e;
      e = elem_at(bus_pos);
      case (e)
         E_START: begin
            if (slot_idx == 0) sda_q = 1'b0;
            else scl_q = 1'b0;
         end
         E_OADRW, E_OADRR, E_OREG, E_ODATA, E_NACK: begin
            if (slot_idx == 0) begin
               scl_q = 1'b0;
            end else begin
               sda_q = (e == E_NACK) ? 1'b1 : shift_q[7];
               scl_q = 1'b1;
            end
         end
         E_ACK, E_IN: begin
            if (slot_idx == 0) begin
               scl_q = 1'b0;
            end else if (slot_idx == 1) begin
               sda_q = 1'b1;
               scl_q = 1'b1;
            end else if (e == E_IN) begin
               shift_q = {shift_q[6:0], sda_in};
            end
         end
         E_STOP: begin
            case (slot_idx)
               3'd0:    scl_q = 1'b0;
               3'd1:    sda_q = 1'b0;
               3'd2:    scl_q = 1'b1;
               default: sda_q = 1'b1;
            endcase
         end
         default: ;
      endcase
   endtask

   task automatic next_slot(input logic sda_in, output logic done, output logic rvalid);
      elem_type   e;
      logic       more;
      logic [7:0] m;
      e = elem_at(bus_pos);
      done = 1'b0;
      rvalid = 1'b0;
      more = 1'b0;
      slot_idx = slot_idx + 3'd1;
      if (slot_idx < slot_total(e)) begin
         act_slot(sda_in);
      end else begin
         slot_idx = '0;
         if (sends_byte(e)) shift_q = shift_q << 1;
         if (sends_byte(e) || e == E_IN) begin
            bit_cnt = bit_cnt + 4'd1;
            more = bit_cnt < 4'd8;
         end
         if (more) begin
            act_slot(sda_in);
         end else begin
            // end of the read byte: keep it or fold in the bit change
            if (e == E_IN && cmd_op == OP_READ) begin
               read_q = shift_q;
            end else if (e == E_IN && cmd_op == OP_SET_BIT) begin
               m = 8'h01 << cmd_pos;
               cmd_data = cmd_bitv ? (shift_q | m) : (shift_q & ~m);
            end
            bus_pos = bus_pos + 6'd1;
            if (elem_at(bus_pos) == E_END) begin
               busy_q = 1'b0;
               done = 1'b1;
               rvalid = (cmd_op == OP_READ);
            end else begin
               begin_elem();
               act_slot(sda_in);
            end
         end
      end
   endtask

   task automatic i2c_bus_step(input tick_word_t w, output bus_levels_t r);
      logic [8:0] cnt;
      logic       done;
      logic       rvalid;
      done = 1'b0;
      rvalid = 1'b0;
      if (!busy_q) begin
         if (w.cmd_valid) begin
            cmd_op = w.op;
            cmd_dev = w.dev;
            cmd_reg = w.reg_idx;
            cmd_data = w.data;
            cmd_pos = w.pos;
            cmd_bitv = w.bitv;
            busy_q = 1'b1;
            pause_cnt = '0;
            bus_pos = seq_start(w.op);
            begin_elem();
            act_slot(w.sda);
         end
      end else if (w.tick) begin
         cnt = {1'b0, pause_cnt} + 9'd1;
         if (cnt >= {1'b0, cfg_pause}) begin
            pause_cnt = '0;
            next_slot(w.sda, done, rvalid);
         end else begin
            pause_cnt = cnt[7:0];
         end
      end
      r.scl = scl_q;
      r.sda_low = !sda_q;
      r.busy = busy_q;
      r.done = done;
      r.rvalid = rvalid;
      r.rdata = read_q;
   endtask

   function automatic tick_word_t random_word(input int tick_pct, input int cmd_pct);
      tick_word_t w;
      w.tick = $urandom_range(0, 99) < tick_pct;
      w.cmd_valid = $urandom_range(0, 99) < cmd_pct;
      w.op = op_type'($urandom_range(0, 3));
      w.dev = 3'($urandom_range(0, 7));
      w.reg_idx = 8'($urandom_range(0, 255));
      w.data = 8'($urandom_range(0, 255));
      w.pos = 3'($urandom_range(0, 7));
      w.bitv = 1'($urandom_range(0, 1));
      w.sda = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // driver
   tick_word_t cur_word;
   int         gap_left = 0;

   always @(posedge clock) begin
      bus_levels_t lv;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            i2c_bus_step(cur_word, lv);
            expected_levels.push_back(lv);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (idle_en && $urandom_range(0, 15) == 0) begin
               gap_left = $urandom_range(0, 12);
               req_valid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
               cur_word = pending_ticks.pop_front();
               req_tick <= cur_word.tick;
               req_cmd_valid <= cur_word.cmd_valid;
               req_operation <= cur_word.op;
               req_device <= cur_word.dev;
               req_register_index <= cur_word.reg_idx;
               req_data_byte <= cur_word.data;
               req_bit_position <= cur_word.pos;
               req_bit_value <= cur_word.bitv;
               req_sda_in <= cur_word.sda;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_req_id != hold_seen_id) begin
         hold_seen_id <= hold_req_id;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // monitor
   int stall_left = 0;

   always @(posedge clock) begin
      bus_levels_t want;
      logic        st;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: response word with none expected", $time);
               mismatch_count++;
            end else begin
               want = expected_levels.pop_front();
               check_field("scl_level", 8'(want.scl), 8'(rsp_scl_level));
               check_field("sda_pull_low", 8'(want.sda_low), 8'(rsp_sda_pull_low));
               check_field("busy_res", 8'(want.busy), 8'(rsp_busy_res));
               check_field("done_res", 8'(want.done), 8'(rsp_done_res));
               check_field("read_valid", 8'(want.rvalid), 8'(rsp_read_valid));
               check_field("read_data", want.rdata, rsp_read_data);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            st = 1'b1;
         end else if (idle_en && $urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 12);
            st = 1'b1;
         end else begin
            st = 1'b0;
         end
         rsp_stall <= st || (hold_left != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic bit all_sent();
      return pending_ticks.size() == 0 && !req_valid;
   endfunction

   // feed plain ticks until the predicted command has finished
   task automatic drain_to_idle();
      do begin
         while (!all_sent()) @(negedge clock);
         if (busy_q)
            for (int i = 0; i < 32; i++) pending_ticks.push_back(random_word(100, 0));
      end while (busy_q);
   endtask

   task automatic settle();
      drain_to_idle();
      while (expected_levels.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PAUSE_TICKS) cfg_pause = val;
      else cfg_addr_base = val[6:0];
      @(negedge clock);
   endtask

   task automatic run_cmd(input op_type op, input logic [2:0] dev, input logic [7:0] ridx,
                          input logic [7:0] data, input logic [2:0] pos, input logic bitv);
      tick_word_t w;
      w = random_word(50, 100);
      w.op = op;
      w.dev = dev;
      w.reg_idx = ridx;
      w.data = data;
      w.pos = pos;
      w.bitv = bitv;
      pending_ticks.push_back(w);
      drain_to_idle();
   endtask

   task automatic random_phase(input int n, input bit with_hold);
      for (int i = 0; i < n; i++) pending_ticks.push_back(random_word(85, 12));
      if (with_hold) begin
         while (pending_ticks.size() > n - 200) @(negedge clock);
         hold_req_id++;
      end
      settle();
   endtask

   initial begin
      tick_word_t w;
      bus_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_en = 1'b1;

      // reset settings: idle words, a read, then a command while busy
      pending_ticks.push_back(random_word(100, 0));
      pending_ticks.push_back(random_word(0, 0));
      w = random_word(100, 100);
      w.op = OP_READ;
      w.dev = 3'd0;
      pending_ticks.push_back(w);
      w = random_word(100, 100);
      w.op = OP_WRITE_REG;
      pending_ticks.push_back(w);
      settle();

      // shortest pause, address base with every bit set
      csr_write(CSR_PAUSE_TICKS, 8'd1);
      csr_write(CSR_ADDRESS_BASE, 8'hff);
      run_cmd(OP_WRITE_REG, 3'd7, 8'hff, 8'hff, 3'd0, 1'b0);
      run_cmd(OP_SET_BIT, 3'd7, 8'h80, 8'h00, 3'd7, 1'b1);
      run_cmd(OP_SET_BIT, 3'd1, 8'h01, 8'haa, 3'd0, 1'b0);
      run_cmd(OP_SELECT_REG, 3'd3, 8'h5a, 8'h00, 3'd3, 1'b1);
      settle();

      // zero pause, zero address base
      csr_write(CSR_PAUSE_TICKS, 8'd0);
      csr_write(CSR_ADDRESS_BASE, 8'h00);
      run_cmd(OP_READ, 3'd5, 8'h00, 8'h00, 3'd0, 1'b0);
      run_cmd(OP_SELECT_REG, 3'd0, 8'h00, 8'h00, 3'd0, 1'b0);
      run_cmd(OP_WRITE_REG, 3'd0, 8'h00, 8'h00, 3'd0, 1'b0);
      run_cmd(OP_READ, 3'd7, 8'hff, 8'hff, 3'd7, 1'b1);
      settle();

      // longest pause for a few slots, then a short pause mid command
      idle_en = 1'b0;
      csr_write(CSR_PAUSE_TICKS, 8'd255);
      csr_write(CSR_ADDRESS_BASE, 8'h55);
      w = random_word(100, 100);
      w.op = OP_SELECT_REG;
      w.dev = 3'd2;
      w.reg_idx = 8'ha5;
      w.data = 8'h3c;
      w.pos = 3'd4;
      w.bitv = 1'b0;
      pending_ticks.push_back(w);
      for (int i = 0; i < 520; i++) pending_ticks.push_back(random_word(100, 0));
      while (!all_sent() || expected_levels.size() != 0) @(negedge clock);
      csr_write(CSR_PAUSE_TICKS, 8'd1);
      settle();

      // random traffic
      idle_en = 1'b1;
      csr_write(CSR_PAUSE_TICKS, 8'd1);
      csr_write(CSR_ADDRESS_BASE, 8'd64);
      random_phase(250, 1'b1);
      csr_write(CSR_PAUSE_TICKS, 8'd0);
      csr_write(CSR_ADDRESS_BASE, 8'h2b);
      random_phase(100, 1'b0);
      csr_write(CSR_PAUSE_TICKS, 8'd2);
      csr_write(CSR_ADDRESS_BASE, 8'h7f);
      random_phase(80, 1'b0);

      // last part without idling
      idle_en = 1'b0;
      csr_write(CSR_PAUSE_TICKS, 8'd3);
      csr_write(CSR_ADDRESS_BASE, 8'h40);
      random_phase(120, 1'b0);

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/i2crm_pkg.sv
rtl/core/i2c_register_master_core.sv
test/i2c_register_master_core_tb.sv
